FILE: rtl/bsc_pkg.sv
// bsc_pkg: types, codes and pipeline stage records for the barrel shifter with carry
// used by every module of the block; depends on nothing
package bsc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned ROT_W  = 5;

   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] RRX_MASK = 32'h7FFF_FFFF;
   localparam logic [ROT_W-1:0]  TOP_BIT  = 5'd31;
   localparam logic [7:0]        AMT_32   = 8'd32;

   // shift kinds
   localparam logic [1:0] KIND_LSL = 2'd0;
   localparam logic [1:0] KIND_LSR = 2'd1;
   localparam logic [1:0] KIND_ASR = 2'd2;
   localparam logic [1:0] KIND_ROR = 2'd3;

   // what fills the bits the shift leaves empty
   localparam logic [1:0] FILL_ZERO  = 2'd0;
   localparam logic [1:0] FILL_SIGN  = 2'd1;
   localparam logic [1:0] FILL_CARRY = 2'd2;

   // where the carry-out comes from
   localparam logic [1:0] CSEL_CIN  = 2'd0;
   localparam logic [1:0] CSEL_BIT  = 2'd1;
   localparam logic [1:0] CSEL_ZERO = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] operand;
      logic [1:0]        shift_kind;
      logic [7:0]        shift_amount;
      logic              amount_from_register;
      logic              carry_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] shifted;
      logic              shift_carry;
   } rsp_type;

   // after decode: every shift expressed as rotate right, mask and fill
   typedef struct packed {
      logic [DATA_W-1:0] operand;
      logic [ROT_W-1:0]  rot;
      logic [DATA_W-1:0] mask;
      logic [1:0]        fill_sel;
      logic [1:0]        carry_sel;
      logic [ROT_W-1:0]  carry_idx;
      logic              carry_in;
   } dec_type;

   // after the coarse rotate
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [1:0]        rot_fine;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] fill;
      logic              shift_carry;
   } rot_type;

endpackage

FILE: rtl/barrel_shifter_with_carry.sv
// barrel_shifter_with_carry: three-stage shifter pipeline with carry-out
// depends on bsc_pkg, bsc_decode, bsc_rotate and bsc_merge
//
// usage
//   req_valid/req_data carry one request: operand, shift kind (lsl, lsr, asr,
//   ror/rrx), 8-bit amount, amount-from-register flag and the current carry.
//   rsp_valid/rsp_data return the shifted value and the shifter carry-out,
//   exactly one response per request, in request order.
//   a transfer happens on a rising edge with valid high and stall low.
// stages: decode, coarse rotate, then fine rotate and merge, each registered;
//   the last stage register drives rsp_data.
// throughput: one request per cycle with no stall.
// stall: each stage loads when it is empty or the stage after it moves, so
//   bubbles are squeezed out; req_stall rises only when all three stages hold
//   a request and rsp_stall is high. nothing is dropped or repeated.
// reset: synchronous, clears the stage valid bits; no other state is kept.
module barrel_shifter_with_carry (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsc_pkg::rsp_type rsp_data
);

   logic             dec_valid;
   bsc_pkg::dec_type dec_data;
   logic             rot_valid;
   bsc_pkg::rot_type rot_data;

   logic load_dec;
   logic load_rot;
   logic load_mrg;

   assign load_mrg  = !rsp_valid || !rsp_stall;
   assign load_rot  = !rot_valid || load_mrg;
   assign load_dec  = !dec_valid || load_rot;
   assign req_stall = !load_dec;

   bsc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .load      (load_dec),
      .out_valid (dec_valid),
      .out_data  (dec_data)
   );

   bsc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .load      (load_rot),
      .out_valid (rot_valid),
      .out_data  (rot_data)
   );

   bsc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_data   (rot_data),
      .load      (load_mrg),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

FILE: rtl/bsc_decode.sv
// bsc_decode: first stage, turns kind and amount into rotate amount, mask, fill and carry source
// depends on bsc_pkg
module bsc_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bsc_pkg::req_type in_data,
   input  logic             load,
   output logic             out_valid,
   output bsc_pkg::dec_type out_data
);

   logic             valid_ff;
   bsc_pkg::dec_type data_ff;
   bsc_pkg::dec_type data_in;

   logic [7:0]                amt;
   logic [bsc_pkg::ROT_W-1:0] amt_lo;
   logic                      below_32;
   logic                      is_32;

   assign amt      = in_data.shift_amount;
   assign amt_lo   = amt[bsc_pkg::ROT_W-1:0];
   assign below_32 = (amt < bsc_pkg::AMT_32);
   assign is_32    = (amt == bsc_pkg::AMT_32);

   always_comb begin
      data_in           = '0;
      data_in.operand   = in_data.operand;
      data_in.carry_in  = in_data.carry_in;
      data_in.rot       = '0;
      data_in.mask      = bsc_pkg::ALL_ONES;
      data_in.fill_sel  = bsc_pkg::FILL_ZERO;
      data_in.carry_sel = bsc_pkg::CSEL_CIN;
      data_in.carry_idx = '0;
      if (amt == 8'd0) begin
         if (in_data.shift_kind != bsc_pkg::KIND_LSL && !in_data.amount_from_register) begin
            case (in_data.shift_kind)
               bsc_pkg::KIND_LSR: begin
                  data_in.mask      = '0;
                  data_in.carry_sel = bsc_pkg::CSEL_BIT;
                  data_in.carry_idx = bsc_pkg::TOP_BIT;
               end
               bsc_pkg::KIND_ASR: begin
                  data_in.mask      = '0;
                  data_in.fill_sel  = bsc_pkg::FILL_SIGN;
                  data_in.carry_sel = bsc_pkg::CSEL_BIT;
                  data_in.carry_idx = bsc_pkg::TOP_BIT;
               end
               default: begin
                  // rrx: rotate by one, old carry into the top bit
                  data_in.rot       = 5'd1;
                  data_in.mask      = bsc_pkg::RRX_MASK;
                  data_in.fill_sel  = bsc_pkg::FILL_CARRY;
                  data_in.carry_sel = bsc_pkg::CSEL_BIT;
                  data_in.carry_idx = 5'd0;
               end
            endcase
         end
      end else begin
         case (in_data.shift_kind)
            bsc_pkg::KIND_LSL: begin
               if (below_32) begin
                  // left shift is a right rotate by 32 - n with the low bits masked
                  data_in.rot       = 5'd0 - amt_lo;
                  data_in.mask      = bsc_pkg::ALL_ONES << amt_lo;
                  data_in.carry_sel = bsc_pkg::CSEL_BIT;
                  data_in.carry_idx = 5'd0 - amt_lo;
               end else begin
                  data_in.mask      = '0;
                  data_in.carry_sel = is_32 ? bsc_pkg::CSEL_BIT : bsc_pkg::CSEL_ZERO;
                  data_in.carry_idx = 5'd0;
               end
            end
            bsc_pkg::KIND_LSR, bsc_pkg::KIND_ASR: begin
               if (in_data.shift_kind == bsc_pkg::KIND_ASR) begin
                  data_in.fill_sel = bsc_pkg::FILL_SIGN;
               end
               if (below_32) begin
                  data_in.rot       = amt_lo;
                  data_in.mask      = bsc_pkg::ALL_ONES >> amt_lo;
                  data_in.carry_sel = bsc_pkg::CSEL_BIT;
                  data_in.carry_idx = amt_lo - 5'd1;
               end else begin
                  data_in.mask      = '0;
                  data_in.carry_idx = bsc_pkg::TOP_BIT;
                  if (is_32 || in_data.shift_kind == bsc_pkg::KIND_ASR) begin
                     data_in.carry_sel = bsc_pkg::CSEL_BIT;
                  end else begin
                     data_in.carry_sel = bsc_pkg::CSEL_ZERO;
                  end
               end
            end
            default: begin
               data_in.carry_sel = bsc_pkg::CSEL_BIT;
               if (amt_lo == 5'd0) begin
                  data_in.carry_idx = bsc_pkg::TOP_BIT;
               end else begin
                  data_in.rot       = amt_lo;
                  data_in.carry_idx = amt_lo - 5'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/bsc_rotate.sv
// bsc_rotate: second stage, coarse rotate by multiples of four, fill pattern and carry pick
// depends on bsc_pkg
module bsc_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bsc_pkg::dec_type in_data,
   input  logic             load,
   output logic             out_valid,
   output bsc_pkg::rot_type out_data
);

   logic             valid_ff;
   bsc_pkg::rot_type data_ff;
   bsc_pkg::rot_type data_in;

   logic [2*bsc_pkg::DATA_W-1:0] doubled;
   logic [2*bsc_pkg::DATA_W-1:0] rotated;
   logic [bsc_pkg::ROT_W-1:0]    coarse;

   assign doubled = {in_data.operand, in_data.operand};
   assign coarse  = {in_data.rot[bsc_pkg::ROT_W-1:2], 2'b00};
   assign rotated = doubled >> coarse;

   always_comb begin
      data_in          = '0;
      data_in.value    = rotated[bsc_pkg::DATA_W-1:0];
      data_in.rot_fine = in_data.rot[1:0];
      data_in.mask     = in_data.mask;
      case (in_data.fill_sel)
         bsc_pkg::FILL_SIGN:  data_in.fill = {bsc_pkg::DATA_W{in_data.operand[bsc_pkg::DATA_W-1]}};
         bsc_pkg::FILL_CARRY: data_in.fill = {bsc_pkg::DATA_W{in_data.carry_in}};
         default:             data_in.fill = '0;
      endcase
      case (in_data.carry_sel)
         bsc_pkg::CSEL_BIT:  data_in.shift_carry = in_data.operand[in_data.carry_idx];
         bsc_pkg::CSEL_ZERO: data_in.shift_carry = 1'b0;
         default:            data_in.shift_carry = in_data.carry_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/bsc_merge.sv
// bsc_merge: last stage, fine rotate by 0 to 3 and merge with the fill under the mask
// depends on bsc_pkg; its register is the result register of the block
module bsc_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bsc_pkg::rot_type in_data,
   input  logic             load,
   output logic             out_valid,
   output bsc_pkg::rsp_type out_data
);

   logic             valid_ff;
   bsc_pkg::rsp_type data_ff;
   bsc_pkg::rsp_type data_in;

   logic [2*bsc_pkg::DATA_W-1:0] doubled;
   logic [2*bsc_pkg::DATA_W-1:0] rotated;
   logic [bsc_pkg::DATA_W-1:0]   fine;

   assign doubled = {in_data.value, in_data.value};
   assign rotated = doubled >> in_data.rot_fine;
   assign fine    = rotated[bsc_pkg::DATA_W-1:0];

   always_comb begin
      data_in.shifted     = (fine & in_data.mask) | (in_data.fill & ~in_data.mask);
      data_in.shift_carry = in_data.shift_carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
